// ===== hw/rtl/imd_pkg.sv =====
// Shared types and constants for the intent message deframer.
// No dependencies; every other file in hw/rtl imports this package.
package imd_pkg;

    localparam int CNT_W = 36;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HDR_LEN = CNT_W'(40);
    localparam logic [CNT_W-1:0] ROOT_BYTES = CNT_W'(32);
    localparam logic [31:0] MAGIC_WORD = 32'h5058_494e;
    localparam logic [15:0] HDR_SIZE = 16'd40;
    localparam logic [15:0] VERSION_RESET = 16'd1;
    localparam int NUM_LEN = 5;
    localparam int LEN_IDX_W = $clog2(NUM_LEN);
    localparam int NUM_BND = 7;

    // front-to-back queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // header byte offsets
    localparam logic [5:0] OFS_VER_HI = 6'd4;
    localparam logic [5:0] OFS_VER_LO = 6'd5;
    localparam logic [5:0] OFS_SIZE_HI = 6'd6;
    localparam logic [5:0] OFS_SIZE_LO = 6'd7;
    localparam logic [5:0] OFS_FLAGS = 6'd8;
    localparam logic [5:0] OFS_CORR = 6'd12;
    localparam logic [5:0] OFS_LEN = 6'd20;
    localparam logic [5:0] OFS_HDR_LAST = 6'd39;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_UNSUP   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SEG_HEADER = 3'd0,
        SEG_ROOT   = 3'd1,
        SEG_APP_ID = 3'd2,
        SEG_ACTION = 3'd3,
        SEG_URI    = 3'd4,
        SEG_MIME   = 3'd5,
        SEG_ARGS   = 3'd6,
        SEG_EXCESS = 3'd7
    } seg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  echo_byte;
        seg_t        segment;
        logic        message_end;
        status_t     status;
        logic [31:0] flags;
        logic [63:0] corr_id;
    } out_item_t;

    // queue state seen by the front and back sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

// ===== hw/rtl/imd_front.sv =====
// Front side: byte counter, header capture and checks, segment bounds, tagging.
// Builds one result word per accepted byte. Uses imd_pkg.
module imd_front
    import imd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    in_item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output out_item_t   result
);

    logic [CNT_W-1:0] count_reg, count_next;
    status_t          err_reg, err_next;
    logic [15:0]      ver_reg;
    logic [7:0]       size_hi_reg;
    logic [31:0]      flags_reg;
    logic [63:0]      corr_reg;
    logic [31:0]      len_reg [NUM_LEN];
    logic [CNT_W-1:0] bnd_reg [1:NUM_BND-1];
    logic [CNT_W-1:0] acc_reg;

    logic [CNT_W-1:0] p;
    logic             in_hdr;
    logic [5:0]       p6;
    logic [5:0]       len_ofs;
    logic [LEN_IDX_W-1:0] k;
    logic             len_done;
    logic [31:0]      len_word;
    logic [CNT_W-1:0] base, sum, bnd6_eff;
    logic [7:0]       b;
    logic [7:0]       magic_b;
    seg_t             seg;
    status_t          st;

    assign p = count_reg;
    assign b = in_item.data_byte;
    assign in_hdr = p < HDR_LEN;
    assign p6 = p[5:0];
    assign len_ofs = p6 - OFS_LEN;
    assign k = LEN_IDX_W'(len_ofs[4:2]);
    assign len_word = {len_reg[k][23:0], b};
    assign len_done = in_hdr && (p6 >= OFS_LEN) && (len_ofs[1:0] == 2'b11);

    // running bound: root bound folds in on the app-id length
    assign base = (k == '0)
                ? HDR_LEN + ((len_word != 32'd0) ? ROOT_BYTES : '0)
                : acc_reg;
    assign sum = base + CNT_W'(len_word);

    assign count_next = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        case (p6[1:0])
            2'd0:    magic_b = MAGIC_WORD[31:24];
            2'd1:    magic_b = MAGIC_WORD[23:16];
            2'd2:    magic_b = MAGIC_WORD[15:8];
            default: magic_b = MAGIC_WORD[7:0];
        endcase
    end

    always_comb
    begin
        err_next = err_reg;
        if (in_hdr) begin
            if (p6 < OFS_VER_HI) begin
                if (magic_b != b)
                    err_next = ST_INVALID;
            end else if (p6 == OFS_VER_HI) begin
                if (ver_reg[15:8] != b)
                    err_next = ST_INVALID;
            end else if (p6 == OFS_VER_LO) begin
                if (ver_reg[7:0] != b)
                    err_next = ST_INVALID;
            end else if (p6 == OFS_SIZE_LO) begin
                if ({size_hi_reg, b} != HDR_SIZE && err_reg == ST_OK)
                    err_next = ST_UNSUP;
            end
        end
    end

    always_comb
    begin
        seg = SEG_EXCESS;
        for (int i = NUM_BND - 1; i >= 1; i--) begin
            if (p < bnd_reg[i])
                seg = seg_t'(3'(i));
        end
        if (in_hdr)
            seg = SEG_HEADER;
    end

    // bound 6 is still being summed when the last header byte ends the message
    assign bnd6_eff = (in_hdr && p6 == OFS_HDR_LAST) ? sum : bnd_reg[NUM_BND-1];

    always_comb
    begin
        if (count_next < HDR_LEN)
            st = ST_INVALID;
        else if (err_reg != ST_OK)
            st = err_reg;
        else if (count_next != bnd6_eff)
            st = ST_INVALID;
        else
            st = ST_OK;
    end

    always_comb
    begin
        result.echo_byte = b;
        result.segment = seg;
        result.message_end = in_item.last_byte;
        result.status = ST_OK;
        result.flags = '0;
        result.corr_id = '0;
        if (in_item.last_byte) begin
            result.status = st;
            if (st == ST_OK) begin
                result.flags = flags_reg;
                result.corr_id = corr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            err_reg <= ST_OK;
            ver_reg <= VERSION_RESET;
        end else begin
            if (cfg_we)
                ver_reg <= cfg_data;
            if (accept) begin
                if (in_item.last_byte) begin
                    count_reg <= '0;
                    err_reg <= ST_OK;
                end else begin
                    count_reg <= count_next;
                    err_reg <= err_next;
                end
            end
        end
    end

    // header words are fully overwritten before use, so no clear needed
    always_ff @(posedge clk)
    begin
        if (accept && in_hdr) begin
            if (p6 == OFS_SIZE_HI)
                size_hi_reg <= b;
            if (p6 >= OFS_FLAGS && p6 < OFS_CORR)
                flags_reg <= {flags_reg[23:0], b};
            if (p6 >= OFS_CORR && p6 < OFS_LEN)
                corr_reg <= {corr_reg[55:0], b};
            if (p6 >= OFS_LEN)
                len_reg[k] <= len_word;
            if (len_done) begin
                acc_reg <= sum;
                bnd_reg[k + LEN_IDX_W'(2)] <= sum;
                if (k == '0)
                    bnd_reg[1] <= base;
            end
        end
    end

endmodule

// ===== hw/rtl/imd_queue.sv =====
// Two-word queue between the front and back sides.
// Entries are plain registers; uses imd_pkg.
module imd_queue
    import imd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      pop,
    output out_item_t head_item,
    output q_status_t q_status
);

    out_item_t          mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   cnt_reg;

    assign head_item = mem[rd_ptr_reg];
    assign q_status.full = cnt_reg == (Q_PTR_W+1)'(Q_DEPTH);
    assign q_status.not_empty = cnt_reg != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/imd_back.sv =====
// Back side: output register that drains the queue toward the consumer.
// Uses imd_pkg.
module imd_back
    import imd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  out_item_t head_item,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // refill when empty or when the held word leaves this cycle
    assign pop = q_status.not_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || !out_stall)
            out_valid_reg <= q_status.not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= head_item;
    end

endmodule

// ===== hw/rtl/intent_message_deframer_unit.sv =====
// Top level of the intent message deframer: front, queue and back sides.
// Depends on imd_pkg, imd_front, imd_queue, imd_back.
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+----------------------
//  in      | in_valid, in_stall, in_data      | in        | data byte, last flag
//  out     | out_valid, out_stall, out_data   | out       | tagged byte + status
//  cfg     | cfg_valid, cfg_ready, cfg_data   | in        | expected version
//
// One byte per cycle sustained while out_stall is low; an accepted word is written to
// the queue, then loaded into the output register, which drives out_valid and out_data.
// in_stall is high while the two-word queue is full; up to three words are
// buffered between the ports. cfg_ready is always high.
// Reset clears the counter, error state and queue; the version resets to 1.
module intent_message_deframer_unit
    import imd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic      accept;
    logic      pop;
    out_item_t result;
    out_item_t head_item;
    q_status_t q_status;

    assign in_stall = q_status.full;
    assign accept = in_valid && !q_status.full;
    assign cfg_ready = 1'b1;

    imd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_item  (in_data),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .result   (result)
    );

    imd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (result),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    imd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
